@@ rtl/base64_stream_decoder_top_assert.svh @@
// ----------------------------------------------------------------------------
// Base64 stream decoder assertion macros
// Shorthand for clocked checks on the top level, sampled at the rising edge
// of clock and switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_TOP_ASSERT_SVH
`define BASE64_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define B64_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define B64_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/b64_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decoder package
// Result codes, bundle types and the alphabet lookup shared by the decoder.
// ----------------------------------------------------------------------------
package b64_pkg;

   typedef enum logic [1:0] {
      ST_BYTE = 2'd0,
      ST_END  = 2'd1,
      ST_ERR  = 2'd2
   } b64_status_type;

   localparam int unsigned MaxResults = 4;

   localparam logic [7:0]  SymLow   = 8'd43;
   localparam logic [7:0]  SymHigh  = 8'd122;
   localparam logic [7:0]  SymPad   = 8'h3D;
   localparam logic [31:0] MaxCount = 32'hFFFF_FFFF;

   // One result of a bundle; inc is what the total adds to the bundle base.
   typedef struct packed {
      b64_status_type status;
      logic [7:0]     data;
      logic [1:0]     inc;
   } b64_entry_type;

   // All results caused by one input item.
   typedef struct packed {
      logic [2:0]                       count;
      logic [31:0]                      base;
      b64_entry_type [MaxResults-1:0]   entry;
   } b64_bundle_type;

   // One result as it leaves the queue.
   typedef struct packed {
      b64_status_type status;
      logic [7:0]     data;
      logic [31:0]    total;
      logic           last;
   } b64_result_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } b64_sextet_type;

   function automatic b64_sextet_type sextet_of(input logic [7:0] c);
      b64_sextet_type r;
      r.valid = 1'b0;
      r.value = '0;
      if (c >= SymLow && c <= SymHigh) begin
         if (c inside {[8'h41:8'h5A]}) begin
            r.valid = 1'b1;
            r.value = 6'(c - 8'h41);
         end else if (c inside {[8'h61:8'h7A]}) begin
            r.valid = 1'b1;
            r.value = 6'(c - 8'h61 + 8'd26);
         end else if (c inside {[8'h30:8'h39]}) begin
            r.valid = 1'b1;
            r.value = 6'(c - 8'h30 + 8'd52);
         end else if (c == 8'h2B) begin
            r.valid = 1'b1;
            r.value = 6'd62;
         end else if (c == 8'h2F) begin
            r.valid = 1'b1;
            r.value = 6'd63;
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/b64_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 decode core
// Holds the group state and turns one character into a bundle of results.
// ----------------------------------------------------------------------------
module b64_core
   import b64_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     symbol,
   input  logic           first,
   input  logic           last,
   output logic           push,
   output b64_bundle_type bundle
);

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] acc_ff, acc_in;
   logic [31:0] cnt_ff, cnt_in;
   logic        active_ff, active_in;

   logic           eff_active;
   logic [1:0]     eff_pos;
   logic [17:0]    eff_acc;
   logic [31:0]    eff_cnt;
   logic [23:0]    word;
   logic [1:0]     nbytes;
   logic           finish;
   logic [32:0]    cnt_sum;
   b64_sextet_type sx;

   always_comb begin
      // A stream start clears the group before the character is looked at.
      eff_active = first | active_ff;
      eff_pos    = first ? 2'd0 : pos_ff;
      eff_acc    = first ? 18'd0 : acc_ff;
      eff_cnt    = first ? 32'd0 : cnt_ff;
      sx         = sextet_of(symbol);
      word       = {eff_acc, sx.value};

      bundle       = '0;
      bundle.base  = eff_cnt;
      nbytes       = 2'd0;
      finish       = 1'b0;
      pos_in       = eff_pos;
      acc_in       = eff_acc;
      active_in    = eff_active;

      if (eff_active) begin
         if (symbol == SymPad) begin
            finish = 1'b1;
            case (eff_pos)
               2'd0, 2'd1: begin
                  bundle.entry[0].status = ST_ERR;
                  bundle.count           = 3'd1;
               end
               2'd2: begin
                  bundle.entry[0].data   = eff_acc[11:4];
                  bundle.entry[0].inc    = 2'd1;
                  bundle.entry[1].status = ST_END;
                  bundle.entry[1].inc    = 2'd1;
                  bundle.count           = 3'd2;
                  nbytes                 = 2'd1;
               end
               default: begin
                  bundle.entry[0].data   = eff_acc[17:10];
                  bundle.entry[0].inc    = 2'd1;
                  bundle.entry[1].data   = eff_acc[9:2];
                  bundle.entry[1].inc    = 2'd2;
                  bundle.entry[2].status = ST_END;
                  bundle.entry[2].inc    = 2'd2;
                  bundle.count           = 3'd3;
                  nbytes                 = 2'd2;
               end
            endcase
         end else if (!sx.valid) begin
            // Clean end between groups, error inside one.
            finish                 = 1'b1;
            bundle.entry[0].status = (eff_pos == 2'd0) ? ST_END : ST_ERR;
            bundle.count           = 3'd1;
         end else if (eff_pos == 2'd3) begin
            bundle.entry[0].data = word[23:16];
            bundle.entry[0].inc  = 2'd1;
            bundle.entry[1].data = word[15:8];
            bundle.entry[1].inc  = 2'd2;
            bundle.entry[2].data = word[7:0];
            bundle.entry[2].inc  = 2'd3;
            bundle.count         = 3'd3;
            nbytes               = 2'd3;
            pos_in               = 2'd0;
            acc_in               = '0;
            if (last) begin
               finish                 = 1'b1;
               bundle.entry[3].status = ST_END;
               bundle.entry[3].inc    = 2'd3;
               bundle.count           = 3'd4;
            end
         end else begin
            acc_in = {eff_acc[11:0], sx.value};
            pos_in = eff_pos + 2'd1;
            if (last) begin
               finish                 = 1'b1;
               bundle.entry[0].status = ST_ERR;
               bundle.count           = 3'd1;
            end
         end
      end

      if (finish) begin
         active_in = 1'b0;
         pos_in    = 2'd0;
         acc_in    = '0;
      end

      cnt_sum = {1'b0, eff_cnt} + 33'(nbytes);
      cnt_in  = cnt_sum[32] ? MaxCount : cnt_sum[31:0];
      push    = accept && (bundle.count != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         active_ff <= 1'b1;
      end else if (accept) begin
         pos_ff    <= pos_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         active_ff <= active_in;
      end
   end

endmodule

@@ rtl/b64_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 result queue
// Two bundle slots; the head bundle is sent out one result per transfer.
// ----------------------------------------------------------------------------
module b64_queue
   import b64_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  b64_bundle_type bundle,
   output logic           in_ready,
   output logic           out_valid,
   input  logic           out_ready,
   output b64_result_type result
);

   b64_bundle_type slot_ff [2];
   logic           wr_ptr_ff, rd_ptr_ff;
   logic [1:0]     occ_ff, occ_in;
   logic [1:0]     idx_ff, idx_in;

   b64_bundle_type head;
   b64_entry_type  cur;
   logic           last_entry;
   logic           take;
   logic           pop;
   logic [32:0]    total_sum;

   always_comb begin
      head       = slot_ff[rd_ptr_ff];
      cur        = head.entry[idx_ff];
      last_entry = (3'(idx_ff) + 3'd1) == head.count;
      out_valid  = occ_ff != 2'd0;
      in_ready   = occ_ff != 2'd2;
      take       = out_valid && out_ready;
      pop        = take && last_entry;

      total_sum     = {1'b0, head.base} + 33'(cur.inc);
      result.status = cur.status;
      result.data   = cur.data;
      result.total  = total_sum[32] ? MaxCount : total_sum[31:0];
      result.last   = last_entry;

      occ_in = occ_ff + 2'(push) - 2'(pop);
      idx_in = pop ? 2'd0 : (take ? idx_ff + 2'd1 : idx_ff);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         occ_ff    <= '0;
         idx_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         occ_ff <= occ_in;
         idx_ff <= idx_in;
      end
   end

endmodule

@@ rtl/base64_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// A character's bundle is registered in the queue; its first result is offered once the
// bundles ahead of it have left. One character per cycle while each yields at most one result
// and rsp_tready is high; the result port moves one result per cycle while it is high.
// A two-bundle queue between decode core and result port sets these rates.
// Reset: synchronous, clears group, count and queue; the stream is active, awaiting data.
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes one base64 character per transfer into bytes, end and error results.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_top_assert.svh"

module base64_stream_decoder_top
   import b64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Character channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tuser,   // [0] first
   input  logic        req_tlast,   // last
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] byte_out, [39:8] total_bytes
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // end_of_run
);

   logic           accept;
   logic           push;
   b64_bundle_type bundle;
   b64_result_type result;

   // Take a character whenever a bundle slot is free; the core state moves
   // only on a transfer.
   assign accept = req_tvalid && req_tready;

   b64_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .symbol (req_tdata),
      .first  (req_tuser),
      .last   (req_tlast),
      .push   (push),
      .bundle (bundle)
   );

   // Hold the bundles and send them out a result at a time.
   b64_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .bundle    (bundle),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .result    (result)
   );

   assign rsp_tdata = {result.total, result.data};
   assign rsp_tuser = result.status;
   assign rsp_tlast = result.last;

   // End and error results close the run of results for their character.
   `B64_ASSERT_NOW(a_final_is_last, rsp_tvalid && (rsp_tuser != ST_BYTE), rsp_tlast, "end or error result not last of its run")
   // Only byte results carry data.
   `B64_ASSERT_NOW(a_status_no_data, rsp_tvalid && (rsp_tuser != ST_BYTE), rsp_tdata[7:0] == 8'd0, "end or error result carries a byte")
   // A byte result always counts at least itself.
   `B64_ASSERT_NOW(a_byte_counted, rsp_tvalid && (rsp_tuser == ST_BYTE), rsp_tdata[39:8] != 32'd0, "byte result with zero total")
   // After a character gives results, the result port offers a result on the next cycle.
   `B64_ASSERT_NEXT(a_push_shows, push, rsp_tvalid, "pushed bundle not offered")

endmodule
